/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the voice activity segmenter.
// Each macro checks on the rising clock edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`endif

/* design/evas_pkg.sv */
// Package of the energy voice activity segmenter: sizes, codes and payload types.
// Depends on nothing; used by energy_voice_activity_segmenter_core.
`default_nettype none

package evas_pkg;

  localparam int unsigned FRAME_SAMPLES_MAX     = 2048;
  localparam int unsigned MAX_UTTERANCE_SAMPLES = 160000;

  // Early end once kept_length * 5 > MAX * 4, i.e. kept_length > floor(MAX * 4 / 5).
  localparam int unsigned KEPT_EARLY_LIMIT = (MAX_UTTERANCE_SAMPLES * 4) / 5;

  localparam int unsigned CNT_W    = $clog2(FRAME_SAMPLES_MAX + 1);
  localparam int unsigned ENERGY_W = 27;
  localparam int unsigned SUM_W    = ENERGY_W + 1;
  localparam int unsigned PROD_W   = 16 + CNT_W;
  localparam int unsigned CMP_W    = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int unsigned QUIET_W  = 4;
  localparam int unsigned SILENT_W = 17;
  localparam int unsigned KEPT_W   = 18;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [SILENT_W-1:0] SILENT_MAX = '1;
  localparam logic [QUIET_W-1:0]  QUIET_MAX  = '1;
  localparam logic [QUIET_W-1:0]  HANGOVER_FRAMES = QUIET_W'(3);
  localparam logic [QUIET_W-1:0]  END_QUIET_FRAMES = QUIET_W'(4);
  localparam logic [QUIET_W:0]    EARLY_QUIET_ADD = (QUIET_W + 1)'(5);

  typedef enum logic [1:0] {
    CLS_SILENCE = 2'd0,
    CLS_SPEECH  = 2'd1,
    CLS_PAUSE   = 2'd2
  } frame_class_e;

  typedef enum logic [1:0] {
    REG_ENERGY_THRESHOLD = 2'd0,
    REG_SILENCE_LIMIT    = 2'd1,
    REG_WAKE_REQUIRED    = 2'd2,
    REG_ALERT_ENABLE     = 2'd3
  } cfg_reg_e;

  localparam logic ITEM_SAMPLE = 1'b0;
  localparam logic ITEM_WAKE   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic               frame_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        frame_class;
    logic              utterance_end;
    logic [KEPT_W-1:0] utterance_length;
    logic              wake_expired;
    logic              alert_send;
    logic              awake;
  } out_item_t;

endpackage

`default_nettype wire

/* design/energy_voice_activity_segmenter_core.sv */
// Top level of the energy voice activity segmenter: input register, frame
// decision logic, result register. Uses evas_pkg and assert_macros.svh.
//
//   channel | signals                                  | direction
//   in      | in_valid_i, in_ready_o, in_data_i        | item in
//   out     | out_valid_o, out_ready_i, out_data_o     | result out
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,   | register write in
//           | cfg_data_i                               |
//
// An item is held in the input register and, if it ends a frame, its result
// is decided combinationally and written into the output register.
// One item is taken per cycle while the decision stage is not stalled; the rate is
// set by the single decision stage (a 16 x 12 multiply and a 28-bit compare).
// Reset clears all state and loads the register defaults. A result waiting in
// the output register stalls the decision stage only when the next item also ends a frame.
`default_nettype none
`include "assert_macros.svh"

module energy_voice_activity_segmenter_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  evas_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output evas_pkg::out_item_t  out_data_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [1:0]            cfg_index_i,
  input  wire [15:0]           cfg_data_i
);
  import evas_pkg::*;

  // Configuration registers.
  logic [15:0] energy_threshold_q, silence_limit_q;
  logic        wake_required_q, alert_enable_q;

  // Pipeline registers.
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;

  // Segmenter state.
  logic [ENERGY_W-1:0] energy_q, energy_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                seen_q, seen_d;
  logic [QUIET_W-1:0]  quiet_q, quiet_d;
  logic [SILENT_W-1:0] silent_q, silent_d;
  logic                wake_q, wake_d;
  logic [KEPT_W-1:0]   kept_q, kept_d;

  logic                has_result, advance, out_free;
  out_item_t           result;
  logic [16:0]         mag;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    n;
  logic                frame_end;
  logic [PROD_W-1:0]   prod;
  logic                is_speech;
  logic [KEPT_W:0]     kept_sum;
  logic [QUIET_W:0]    quiet_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_threshold_q <= 16'd300;
      silence_limit_q    <= 16'd30;
      wake_required_q    <= 1'b1;
      alert_enable_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ENERGY_THRESHOLD: energy_threshold_q <= cfg_data_i;
        REG_SILENCE_LIMIT:    silence_limit_q    <= cfg_data_i;
        REG_WAKE_REQUIRED:    wake_required_q    <= cfg_data_i[0];
        REG_ALERT_ENABLE:     alert_enable_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Frame arithmetic on the registered item.
  always_comb begin
    mag       = in_q.sample[15] ? (17'h10000 - {1'b0, in_q.sample}) : {1'b0, in_q.sample};
    sum       = {1'b0, energy_q} + SUM_W'(mag);
    n         = count_q + CNT_W'(1);
    frame_end = in_q.frame_last || (n == CNT_W'(FRAME_SAMPLES_MAX));
    prod      = PROD_W'(energy_threshold_q) * PROD_W'(n);
    is_speech = CMP_W'(sum) > CMP_W'(prod);
    kept_sum  = {1'b0, kept_q} + (KEPT_W + 1)'(n);
  end

  always_comb begin
    energy_d   = energy_q;
    count_d    = count_q;
    seen_d     = seen_q;
    quiet_d    = quiet_q;
    silent_d   = silent_q;
    wake_d     = wake_q;
    kept_d     = kept_q;
    has_result = 1'b0;
    quiet_sum  = '0;
    result     = '0;

    if (in_q.kind == ITEM_WAKE) begin
      wake_d   = 1'b1;
      silent_d = '0;
    end else if (!frame_end) begin
      energy_d = (sum > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : sum[ENERGY_W-1:0];
      count_d  = n;
    end else begin
      has_result = 1'b1;
      energy_d   = '0;
      count_d    = '0;
      if (is_speech) begin
        quiet_d  = '0;
        silent_d = '0;
        seen_d   = 1'b1;
        kept_d   = (kept_sum > (KEPT_W + 1)'(MAX_UTTERANCE_SAMPLES))
                   ? KEPT_W'(MAX_UTTERANCE_SAMPLES) : kept_sum[KEPT_W-1:0];
        result.frame_class = CLS_SPEECH;
        result.alert_send  = wake_required_q && !wake_q && alert_enable_q;
      end else begin
        // Pause keeps the frame as hangover; otherwise the frame is dropped.
        if (seen_q && quiet_q < HANGOVER_FRAMES) begin
          kept_d = (kept_sum > (KEPT_W + 1)'(MAX_UTTERANCE_SAMPLES))
                   ? KEPT_W'(MAX_UTTERANCE_SAMPLES) : kept_sum[KEPT_W-1:0];
          result.frame_class = CLS_PAUSE;
        end else begin
          result.frame_class = CLS_SILENCE;
        end
        quiet_d  = (quiet_q == QUIET_MAX) ? QUIET_MAX : quiet_q + QUIET_W'(1);
        silent_d = (silent_q == SILENT_MAX) ? SILENT_MAX : silent_q + SILENT_W'(1);
        if (result.frame_class == CLS_SILENCE && silent_d >= SILENT_W'(silence_limit_q)) begin
          result.wake_expired = wake_required_q && wake_q &&
                                (silent_d == SILENT_W'(silence_limit_q));
          wake_d = 1'b0;
        end
      end

      // A long utterance is forced to end by pushing the quiet count up.
      if (kept_d > KEPT_W'(KEPT_EARLY_LIMIT)) begin
        quiet_sum = {1'b0, quiet_d} + EARLY_QUIET_ADD;
        quiet_d   = (quiet_sum > (QUIET_W + 1)'(QUIET_MAX)) ? QUIET_MAX
                    : quiet_sum[QUIET_W-1:0];
      end

      result.utterance_length = kept_d;
      if (seen_d && quiet_d >= END_QUIET_FRAMES) begin
        result.utterance_end = 1'b1;
        kept_d  = '0;
        quiet_d = '0;
        seen_d  = 1'b0;
      end
      result.awake = wake_d;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!has_result || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      energy_q    <= '0;
      count_q     <= '0;
      seen_q      <= 1'b0;
      quiet_q     <= '0;
      silent_q    <= '0;
      wake_q      <= 1'b0;
      kept_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        energy_q <= energy_d;
        count_q  <= count_d;
        seen_q   <= seen_d;
        quiet_q  <= quiet_d;
        silent_q <= silent_d;
        wake_q   <= wake_d;
        kept_q   <= kept_d;
      end
      if (advance && has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_PROP(a_alert_only_on_speech_asleep, clk_i, rst_ni,
    (out_valid_o && out_data_o.alert_send) |->
      (out_data_o.frame_class == CLS_SPEECH && !out_data_o.awake))
  `ASSERT_PROP(a_expiry_clears_wake, clk_i, rst_ni,
    (out_valid_o && out_data_o.wake_expired) |->
      (out_data_o.frame_class == CLS_SILENCE && !out_data_o.awake))
  `ASSERT_NEVER(a_kept_in_range, clk_i, rst_ni,
    kept_q > KEPT_W'(MAX_UTTERANCE_SAMPLES))
  `ASSERT_PROP(a_open_utterance_quiet_low, clk_i, rst_ni,
    seen_q |-> (quiet_q < END_QUIET_FRAMES))

endmodule

`default_nettype wire

/* tb/energy_voice_activity_segmenter_core_tb.sv */
// Self-checking testbench for energy_voice_activity_segmenter_core: directed frame
// sequences and randomized traffic, all checked against an in-bench predictor.
// Depends on evas_pkg and the core RTL only.
`timescale 1ns / 100ps

module energy_voice_activity_segmenter_core_tb;
  import evas_pkg::*;

  localparam int unsigned TIMEOUT_NS    = 3_000_000;
  localparam int unsigned DRAIN_CYCLES  = 6;
  localparam int unsigned HANGOVER_MAX  = 3;
  localparam int unsigned END_QUIET     = 4;
  localparam int unsigned EARLY_ADD     = 5;
  localparam int unsigned QUIET_SAT     = 15;
  localparam int unsigned SILENT_SAT    = 131071;
  localparam int unsigned RANDOM_PHASES = 4;
  localparam int unsigned PHASE_ITEMS   = 475;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_data   = '0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  cfg_reg_e   cfg_index = REG_ENERGY_THRESHOLD;
  logic [15:0] cfg_data = '0;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_ready;

  // Register copies and frame state of the predictor.
  logic [15:0]         cfg_threshold     = 16'd300;
  logic [15:0]         cfg_silence_limit = 16'd30;
  logic                cfg_wake_req      = 1'b1;
  logic                cfg_alert_en      = 1'b0;
  logic [ENERGY_W-1:0] frame_sum         = '0;
  logic [11:0]         frame_len         = '0;
  logic                talk_seen         = 1'b0;
  logic [QUIET_W-1:0]  quiet_run         = '0;
  logic [SILENT_W-1:0] silent_run        = '0;
  logic                wake_on           = 1'b0;
  logic [KEPT_W-1:0]   kept_samples      = '0;

  out_item_t pending_frames[$];
  out_item_t want;

  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned ends_seen     = 0;
  int unsigned expiries_seen = 0;
  int unsigned alerts_seen   = 0;
  int unsigned burst_left    = 0;
  int unsigned gap_pct       = 30;
  int unsigned sink_mode     = 0;
  int unsigned sink_left     = 0;
  int unsigned sink_tick     = 0;

  energy_voice_activity_segmenter_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    if (error_count < 40) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
    error_count++;
  endtask

  // ---------------------------------------------------------------- predictor
  task automatic grow_kept(input int unsigned n);
    longint unsigned s;
    s = longint'(kept_samples) + n;
    if (s > MAX_UTTERANCE_SAMPLES) s = MAX_UTTERANCE_SAMPLES;
    kept_samples = s[KEPT_W-1:0];
  endtask

  task automatic grow_quiet(input int unsigned k);
    int unsigned s;
    s = quiet_run + k;
    quiet_run = (s > QUIET_SAT) ? QUIET_SAT[QUIET_W-1:0] : s[QUIET_W-1:0];
  endtask

  task automatic bump_silent_run();
    if (silent_run < SILENT_SAT) silent_run++;
  endtask

  // Advances the predicted state by one accepted item and queues the frame
  // decision when the item closes a frame.
  task automatic classify_item(input in_item_t it);
    int              sv;
    int unsigned     mag;
    int unsigned     n;
    longint unsigned total;
    out_item_t       res;
    if (it.kind == ITEM_WAKE) begin
      wake_on    = 1'b1;
      silent_run = '0;
      return;
    end
    sv    = $signed(it.sample);
    mag   = (sv < 0) ? -sv : sv;
    total = longint'(frame_sum) + mag;
    n     = frame_len + 1;
    if (!it.frame_last && n < FRAME_SAMPLES_MAX) begin
      frame_sum = (total > ENERGY_MAX) ? ENERGY_MAX : total[ENERGY_W-1:0];
      frame_len = n[11:0];
      return;
    end
    frame_sum = '0;
    frame_len = '0;
    res       = '0;
    if (total > longint'(cfg_threshold) * n) begin
      quiet_run  = '0;
      silent_run = '0;
      talk_seen  = 1'b1;
      grow_kept(n);
      res.frame_class = CLS_SPEECH;
      if (cfg_wake_req && !wake_on && cfg_alert_en) res.alert_send = 1'b1;
    end else if (talk_seen && quiet_run < HANGOVER_MAX) begin
      grow_kept(n);
      grow_quiet(1);
      bump_silent_run();
      res.frame_class = CLS_PAUSE;
    end else begin
      grow_quiet(1);
      bump_silent_run();
      res.frame_class = CLS_SILENCE;
      if (silent_run >= cfg_silence_limit) begin
        if (cfg_wake_req && silent_run == cfg_silence_limit && wake_on) begin
          res.wake_expired = 1'b1;
        end
        wake_on = 1'b0;
      end
    end
    // Near the length cap the utterance is forced to close.
    if (longint'(kept_samples) * 5 > longint'(MAX_UTTERANCE_SAMPLES) * 4) begin
      grow_quiet(EARLY_ADD);
    end
    res.utterance_length = kept_samples;
    if (talk_seen && quiet_run >= END_QUIET) begin
      res.utterance_end = 1'b1;
      kept_samples      = '0;
      quiet_run         = '0;
      talk_seen         = 1'b0;
    end
    res.awake = wake_on;
    pending_frames.push_back(res);
  endtask

  // ---------------------------------------------------------------- drivers
  function automatic in_item_t sample_item(input int s, input bit last);
    in_item_t it;
    it.kind       = ITEM_SAMPLE;
    it.sample     = 16'(s);
    it.frame_last = last;
    return it;
  endfunction

  // Wake transactions carry random payload bits, which the block must ignore.
  function automatic in_item_t wake_item();
    in_item_t it;
    it.kind       = ITEM_WAKE;
    it.sample     = 16'($urandom_range(0, 65535));
    it.frame_last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [15:0] pick_sample(input int unsigned level);
    int unsigned lo;
    int unsigned hi;
    int          mag;
    lo = level / 2;
    hi = level + level / 2 + 1;
    if (hi > 32767) hi = 32767;
    if (lo > hi) lo = hi;
    mag = $urandom_range(lo, hi);
    if ($urandom_range(0, 1) == 1) mag = -mag;
    return 16'(mag);
  endfunction

  task automatic push_item(input in_item_t it);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    classify_item(it);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 99) < gap_pct) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Waits until every queued frame decision has been checked, then lets the
  // pipeline empty of transactions that produce no result.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ENERGY_THRESHOLD: cfg_threshold     = value;
      REG_SILENCE_LIMIT:    cfg_silence_limit = value;
      REG_WAKE_REQUIRED:    cfg_wake_req      = value[0];
      REG_ALERT_ENABLE:     cfg_alert_en      = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned thr, input int unsigned lim,
                                input bit wreq, input bit aen);
    drain_results();
    write_reg(REG_ENERGY_THRESHOLD, 16'(thr));
    write_reg(REG_SILENCE_LIMIT, 16'(lim));
    write_reg(REG_WAKE_REQUIRED, {15'($urandom_range(0, 32767)), wreq});
    write_reg(REG_ALERT_ENABLE, {15'($urandom_range(0, 32767)), aen});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver
  // Switches among always-ready, random, periodic and mostly-stalled stretches.
  always @(negedge clk) begin
    sink_tick++;
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_left = $urandom_range(20, 200);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 99) < 60);
      2:       out_ready <= (sink_tick % 4 == 0);
      default: out_ready <= ($urandom_range(0, 99) < 10);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_frames.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_frames.pop_front();
        if (out_data.frame_class !== want.frame_class)
          report_error($sformatf("result %0d frame_class %0d, expected %0d",
                                 results_seen, out_data.frame_class, want.frame_class));
        if (out_data.utterance_end !== want.utterance_end)
          report_error($sformatf("result %0d utterance_end %0b, expected %0b",
                                 results_seen, out_data.utterance_end, want.utterance_end));
        if (out_data.utterance_length !== want.utterance_length)
          report_error($sformatf("result %0d utterance_length %0d, expected %0d",
                                 results_seen, out_data.utterance_length,
                                 want.utterance_length));
        if (out_data.wake_expired !== want.wake_expired)
          report_error($sformatf("result %0d wake_expired %0b, expected %0b",
                                 results_seen, out_data.wake_expired, want.wake_expired));
        if (out_data.alert_send !== want.alert_send)
          report_error($sformatf("result %0d alert_send %0b, expected %0b",
                                 results_seen, out_data.alert_send, want.alert_send));
        if (out_data.awake !== want.awake)
          report_error($sformatf("result %0d awake %0b, expected %0b",
                                 results_seen, out_data.awake, want.awake));
        if (want.utterance_end) ends_seen++;
        if (want.wake_expired) expiries_seen++;
        if (want.alert_send) alerts_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // Speech, three hangover frames, then silence closes the utterance.
  task automatic test_hangover_and_end();
    apply_settings(300, 30, 1'b1, 1'b0);
    push_item(sample_item(32767, 1'b0));
    push_item(sample_item(-32768, 1'b1));
    push_item(sample_item(0, 1'b1));
    push_item(sample_item(-1, 1'b0));
    push_item(sample_item(1, 1'b1));
    push_item(sample_item(300, 1'b1));
    push_item(sample_item(0, 1'b1));
    push_item(sample_item(0, 1'b1));
  endtask

  // Alert while asleep, a wake transaction in mid-frame, and expiry exactly
  // at the silence limit.
  task automatic test_wake_expiry_and_alert();
    apply_settings(100, 5, 1'b1, 1'b1);
    push_item(sample_item(5000, 1'b1));
    push_item(sample_item(0, 1'b0));
    push_item(wake_item());
    push_item(sample_item(0, 1'b1));
    push_item(sample_item(0, 1'b1));
    push_item(sample_item(0, 1'b1));
    push_item(sample_item(0, 1'b1));
    push_item(sample_item(0, 1'b1));
    push_item(sample_item(0, 1'b1));
    push_item(wake_item());
    push_item(sample_item(-7, 1'b1));
  endtask

  // A zero silence limit drops the wake state on any silent frame; with gating
  // off no alert fires; a threshold of 32768 never lets a frame count as speech.
  task automatic test_ungated_and_threshold_extremes();
    apply_settings(0, 0, 1'b0, 1'b1);
    push_item(wake_item());
    push_item(sample_item(0, 1'b1));
    push_item(sample_item(1, 1'b1));
    apply_settings(32768, 0, 1'b1, 1'b1);
    push_item(sample_item(-32768, 1'b1));
    push_item(sample_item(32767, 1'b0));
    push_item(sample_item(-32768, 1'b1));
  endtask

  task automatic send_random_frame();
    in_item_t    it;
    int unsigned len;
    int unsigned level;
    int unsigned pick;
    bit          noisy;
    pick = $urandom_range(0, 99);
    if (pick < 85) len = $urandom_range(1, 12);
    else if (pick < 98) len = $urandom_range(13, 64);
    else len = $urandom_range(65, 300);
    pick = $urandom_range(0, 99);
    if (pick < 35) level = cfg_threshold * 3 + 200;
    else if (pick < 60) level = cfg_threshold / 4;
    else if (pick < 75) level = 0;
    else if (pick < 90) level = cfg_threshold;
    else level = 32767;
    noisy = ($urandom_range(0, 99) < 8);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 2) push_item(wake_item());
      it.kind = ITEM_SAMPLE;
      if (noisy) begin
        it.sample     = 16'($urandom_range(0, 65535));
        it.frame_last = ($urandom_range(0, 99) < 20);
      end else begin
        it.sample     = pick_sample(level);
        it.frame_last = (k == len - 1);
      end
      push_item(it);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: apply_settings(0, 0, 1'b1, 1'b1);
        1: apply_settings(32768, 65535, 1'b0, 1'b1);
        default: apply_settings($urandom_range(0, 1500), $urandom_range(1, 8),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_frame();
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("energy_voice_activity_segmenter_core_tb: errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_hangover_and_end();
    test_wake_expiry_and_alert();
    test_ungated_and_threshold_extremes();
    test_random_traffic();
    drain_results();
    $display("Sent %0d transactions; checked %0d frame decisions.", items_sent, results_seen);
    $display("Saw %0d utterance ends, %0d wake expiries and %0d alerts; %0d errors.",
             ends_seen, expiries_seen, alerts_seen, error_count);
    if (error_count == 0) begin
      $display("energy_voice_activity_segmenter_core_tb: clean");
    end else begin
      $display("energy_voice_activity_segmenter_core_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/evas_pkg.sv
design/energy_voice_activity_segmenter_core.sv
tb/energy_voice_activity_segmenter_core_tb.sv
